// ===== src/assert_macros.svh =====
// Assertion macros for the evaluator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define IEC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition");
`else
`define IEC_ASSERT(lbl, prop)
`define IEC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/iec_pkg.sv =====
// ----------------------------------------------------------------------------
// iec_pkg
// Types, constants and helper functions of the infix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package iec_pkg;

  localparam int VALUE_BITS      = 48;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 5;
  localparam int MANT_BITS       = 48;
  localparam int FC_BITS         = $clog2(MAX_FRAC_DIGITS + 1);

  // iterative unit widths
  localparam int WIDE_BITS  = (MANT_BITS > VALUE_BITS) ? MANT_BITS : VALUE_BITS;
  localparam int DIVD_BITS  = WIDE_BITS + FRAC_BITS + 1;
  localparam int DIVR_BITS  = VALUE_BITS;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int MAG_BITS   = (PROD_BITS - FRAC_BITS > DIVD_BITS) ?
                              PROD_BITS - FRAC_BITS : DIVD_BITS;
  localparam int CNT_BITS   = $clog2(DIVD_BITS + 1);

  localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] POW10 [8] = '{64'd1, 64'd10, 64'd100, 64'd1000,
                                        64'd10000, 64'd100000, 64'd1000000,
                                        64'd10000000};

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_TRAIL = 2'd1,
    ERR_DIV0  = 2'd2,
    ERR_OVF   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } pend_e;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CONV_GO,
    ST_CONV_WAIT,
    ST_OP_GO,
    ST_OP_WAIT,
    ST_POST
  } state_e;

  typedef struct packed {
    logic latch;
    logic digit;
    logic conv_go;
    logic conv_done;
    logic op_go;
    logic div0;
    logic op_done;
    logic post;
  } dp_cmd_t;

  typedef struct packed {
    logic  need_finish;
    pend_e pend;
    logic  v_zero;
    logic  unit_done;
    logic  last;
    logic  out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic                  ovf;
    logic [VALUE_BITS-1:0] value;
  } sat_t;

  function automatic logic [DIVR_BITS-1:0] pow10(input logic [FC_BITS-1:0] n);
    pow10 = DIVR_BITS'(POW10[3'(n)]);
  endfunction

  // Signed value from a magnitude, clamped to the value range.
  function automatic sat_t sat_mag(input logic neg, input logic [MAG_BITS-1:0] mag);
    logic [MAG_BITS-1:0] lim;
    logic [MAG_BITS-1:0] m;
    sat_t                r;
    lim     = MAG_BITS'(VMAX) + MAG_BITS'(neg);
    r.ovf   = mag > lim;
    m       = r.ovf ? lim : mag;
    r.value = neg ? VALUE_BITS'(~m + 1'b1) : VALUE_BITS'(m);
    return r;
  endfunction

  function automatic sat_t sat_add(input logic [VALUE_BITS-1:0] a,
                                   input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] s;
    sat_t                r;
    s       = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    r.ovf   = s[VALUE_BITS] ^ s[VALUE_BITS-1];
    r.value = r.ovf ? (s[VALUE_BITS] ? VMIN : VMAX) : s[VALUE_BITS-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/infix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// Character-serial fixed-point evaluator of + - * / expressions.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one ASCII character per transaction; tlast marks
//   the final character of an expression. The master stream returns one
//   transaction per expression: the 48-bit signed value (16 fraction bits)
//   in tdata and the status (ok, trailing operator, divide by zero,
//   overflow) in tuser.
//   A digit, a point or an ignored character passes through the latch and
//   decode steps only. An operator or the last character also runs the
//   number conversion (restoring divide over 65 dividend bits) and then
//   any pending multiply or divide, before the final step; all iterations
//   run on one shared bit-serial unit. The result is registered and
//   appears in the cycle after the final step.
//   Reset clears the expression state and the output valid and status, but not the output value.
//   A waiting result sits in the output register while the next
//   expression is taken in; only the final step of the next expression
//   waits while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator_core
  import iec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,  // [7:0] char_code
  input  wire logic                  s_axis_tlast_i,  // last_char
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [VALUE_BITS-1:0]      m_axis_tdata_o,  // [47:0] result_value
  output logic [1:0]                 m_axis_tuser_o   // [1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  iec_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_char_i    (s_axis_tdata_i),
    .in_last_i    (s_axis_tlast_i),
    .out_ready_i  (m_axis_tready_i),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_value_o  (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== src/iec_muldiv.sv =====
// ----------------------------------------------------------------------------
// iec_muldiv
// Shared iterative unit: shift-add multiply and restoring divide, one bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iec_muldiv
  import iec_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  go_i,
  input  wire mode_e                 mode_i,
  input  wire logic [DIVD_BITS-1:0]  op_a_i,
  input  wire logic [DIVR_BITS-1:0]  op_b_i,
  output logic      [DIVD_BITS-1:0]  quo_o,
  output logic      [PROD_BITS-1:0]  prod_o,
  output logic                       done_o
);

  mode_e                 mode_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  done_q;
  logic [DIVR_BITS-1:0]  b_q;
  logic [VALUE_BITS:0]   acc_q;
  logic [VALUE_BITS-1:0] mq_q;
  logic [DIVR_BITS-1:0]  rem_q;
  logic [DIVD_BITS-1:0]  nq_q;

  logic [VALUE_BITS:0]   sum;
  logic [DIVR_BITS:0]    trial;
  logic                  fit;

  always_comb begin
    sum   = acc_q + ((mq_q[0]) ? (VALUE_BITS+1)'(b_q) : '0);
    trial = {rem_q, nq_q[DIVD_BITS-1]};
    fit   = trial >= {1'b0, b_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      mode_q <= MD_MUL;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        mode_q <= mode_i;
        cnt_q  <= (mode_i == MD_MUL) ? CNT_BITS'(VALUE_BITS) : CNT_BITS'(DIVD_BITS);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      b_q   <= op_b_i;
      acc_q <= '0;
      mq_q  <= op_a_i[VALUE_BITS-1:0];
      rem_q <= '0;
      nq_q  <= op_a_i;
    end else if (cnt_q != '0) begin
      if (mode_q == MD_MUL) begin
        acc_q <= {1'b0, sum[VALUE_BITS:1]};
        mq_q  <= {sum[0], mq_q[VALUE_BITS-1:1]};
      end else begin
        rem_q <= fit ? DIVR_BITS'(trial - {1'b0, b_q}) : trial[DIVR_BITS-1:0];
        nq_q  <= {nq_q[DIVD_BITS-2:0], fit};
      end
    end
  end

  assign quo_o  = nq_q;
  assign prod_o = {acc_q[VALUE_BITS-1:0], mq_q};
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== src/iec_dp.sv =====
// ----------------------------------------------------------------------------
// iec_dp
// Datapath: number assembly, running sum, pending term, sticky error and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iec_dp
  import iec_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_cmd_t                cmd_i,
  input  wire logic [7:0]             in_char_i,
  input  wire logic                   in_last_i,
  input  wire logic                   out_ready_i,
  output dp_stat_t                    stat_o,
  output logic                        out_valid_o,
  output logic [VALUE_BITS-1:0]       out_value_o,
  output logic [1:0]                  out_status_o
);

  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] sum_q, sum_d;
  logic [VALUE_BITS-1:0] term_q, term_d;
  pend_e                 pend_q, pend_d;
  logic                  neg_q, neg_d;
  logic [MANT_BITS-1:0]  mant_q, mant_d;
  logic [FC_BITS-1:0]    fc_q, fc_d;
  logic                  dot_q, dot_d;
  err_e                  err_q, err_d;
  logic [VALUE_BITS-1:0] v_q, v_d;
  logic                  oval_q, oval_d;
  logic [VALUE_BITS-1:0] oval_data_q, oval_data_d;
  err_e                  ostat_q, ostat_d;

  logic                  is_op, is_pm, is_digit;
  logic                  unit_go;
  mode_e                 unit_mode;
  logic [DIVD_BITS-1:0]  op_a;
  logic [DIVR_BITS-1:0]  op_b;
  logic [DIVD_BITS-1:0]  quo;
  logic [PROD_BITS-1:0]  prod;
  logic                  unit_done;

  logic [MANT_BITS+3:0]  tens;
  logic [DIVR_BITS-1:0]  p;
  logic [VALUE_BITS-1:0] term_mag;
  sat_t                  sat;
  sat_t                  sa;
  err_e                  st;

  always_comb begin
    is_op = 1'b0;
    is_pm = 1'b0;
    case (char_q) inside
      CH_PLUS, CH_MINUS: begin
        is_op = 1'b1;
        is_pm = 1'b1;
      end
      CH_STAR, CH_SLASH: is_op = 1'b1;
      default: ;
    endcase
    is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
  end

  iec_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (unit_go),
    .mode_i (unit_mode),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .quo_o  (quo),
    .prod_o (prod),
    .done_o (unit_done)
  );

  always_comb begin
    char_d      = char_q;
    last_d      = last_q;
    sum_d       = sum_q;
    term_d      = term_q;
    pend_d      = pend_q;
    neg_d       = neg_q;
    mant_d      = mant_q;
    fc_d        = fc_q;
    dot_d       = dot_q;
    err_d       = err_q;
    v_d         = v_q;
    oval_d      = oval_q;
    oval_data_d = oval_data_q;
    ostat_d     = ostat_q;
    unit_go     = 1'b0;
    unit_mode   = MD_DIV;
    op_a        = '0;
    op_b        = '0;
    st          = ERR_NONE;

    tens     = ({4'b0, mant_q} << 3) + ({4'b0, mant_q} << 1)
             + (MANT_BITS+4)'(char_q[3:0]);
    p        = pow10(fc_q);
    term_mag = term_q[VALUE_BITS-1] ? (~term_q + 1'b1) : term_q;
    sat      = sat_mag(1'b0, MAG_BITS'(quo));
    sa       = sat_add(sum_q, term_q);

    if (oval_q && out_ready_i) oval_d = 1'b0;

    if (cmd_i.latch) begin
      char_d = in_char_i;
      last_d = in_last_i;
    end

    if (cmd_i.digit) begin
      if (is_digit && (!dot_q || fc_q < FC_BITS'(MAX_FRAC_DIGITS))) begin
        if (tens[MANT_BITS+3:MANT_BITS] != '0) begin
          mant_d = '1;
          if (err_d == ERR_NONE) err_d = ERR_OVF;
        end else begin
          mant_d = tens[MANT_BITS-1:0];
        end
        if (dot_q) fc_d = fc_q + 1'b1;
      end
      if (char_q == CH_DOT) dot_d = 1'b1;
    end

    // conversion: round(mantissa * 2^F / 10^fc), ties upward
    if (cmd_i.conv_go) begin
      unit_go   = 1'b1;
      unit_mode = MD_DIV;
      op_a      = (DIVD_BITS'(mant_q) << FRAC_BITS) + DIVD_BITS'(p >> 1);
      op_b      = p;
    end

    if (cmd_i.conv_done) begin
      v_d = sat.value;
      if (sat.ovf && err_d == ERR_NONE) err_d = ERR_OVF;
      if (pend_q == OP_NONE) term_d = neg_q ? (~sat.value + 1'b1) : sat.value;
      mant_d = '0;
      fc_d   = '0;
      dot_d  = 1'b0;
    end

    if (cmd_i.op_go) begin
      unit_go = 1'b1;
      op_b    = v_q;
      if (pend_q == OP_MUL) begin
        unit_mode = MD_MUL;
        op_a      = DIVD_BITS'(term_mag);
      end else begin
        unit_mode = MD_DIV;
        op_a      = DIVD_BITS'(term_mag) << FRAC_BITS;
      end
    end

    if (cmd_i.div0) begin
      if (err_d == ERR_NONE) err_d = ERR_DIV0;
      term_d = '0;
    end

    if (cmd_i.op_done) begin
      if (pend_q == OP_MUL)
        sat = sat_mag(term_q[VALUE_BITS-1], MAG_BITS'(prod[PROD_BITS-1:FRAC_BITS]));
      else
        sat = sat_mag(term_q[VALUE_BITS-1], MAG_BITS'(quo));
      if (sat.ovf && err_d == ERR_NONE) err_d = ERR_OVF;
      term_d = sat.value;
    end

    if (cmd_i.post) begin
      if (is_pm || (last_q && !is_op)) begin
        sum_d = sa.value;
        if (sa.ovf && err_d == ERR_NONE) err_d = ERR_OVF;
      end
      if (is_pm) begin
        term_d = '0;
        neg_d  = (char_q == CH_MINUS);
        pend_d = OP_NONE;
      end else if (is_op) begin
        pend_d = (char_q == CH_STAR) ? OP_MUL : OP_DIV;
      end
      if (last_q) begin
        if (err_d != ERR_NONE) st = err_d;
        else                   st = is_op ? ERR_TRAIL : ERR_NONE;
        oval_d      = 1'b1;
        ostat_d     = st;
        oval_data_d = (st == ERR_TRAIL || st == ERR_DIV0) ? '0 : sum_d;
        // back to the reset state for the next expression
        sum_d  = '0;
        term_d = '0;
        pend_d = OP_NONE;
        neg_d  = 1'b0;
        mant_d = '0;
        fc_d   = '0;
        dot_d  = 1'b0;
        err_d  = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q  <= '0;
      last_q  <= 1'b0;
      sum_q   <= '0;
      term_q  <= '0;
      pend_q  <= OP_NONE;
      neg_q   <= 1'b0;
      mant_q  <= '0;
      fc_q    <= '0;
      dot_q   <= 1'b0;
      err_q   <= ERR_NONE;
      oval_q  <= 1'b0;
      ostat_q <= ERR_NONE;
    end else begin
      char_q  <= char_d;
      last_q  <= last_d;
      sum_q   <= sum_d;
      term_q  <= term_d;
      pend_q  <= pend_d;
      neg_q   <= neg_d;
      mant_q  <= mant_d;
      fc_q    <= fc_d;
      dot_q   <= dot_d;
      err_q   <= err_d;
      oval_q  <= oval_d;
      ostat_q <= ostat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    oval_data_q <= oval_data_d;
  end

  always_comb begin
    stat_o.need_finish = is_op || last_q;
    stat_o.pend        = pend_q;
    stat_o.v_zero      = (v_q == '0);
    stat_o.unit_done   = unit_done;
    stat_o.last        = last_q;
    stat_o.out_busy    = oval_q && !out_ready_i;
  end

  assign out_valid_o  = oval_q;
  assign out_value_o  = oval_data_q;
  assign out_status_o = ostat_q;

  `IEC_ASSERT_NEVER(a_post_overrun, cmd_i.post && last_q && oval_q && !out_ready_i)
  `IEC_ASSERT(a_conv_after_done, cmd_i.conv_done |-> unit_done)
  `IEC_ASSERT(a_no_div_by_zero, cmd_i.op_go |-> !(pend_q == OP_DIV && v_q == '0))

endmodule

`default_nettype wire

// ===== src/iec_ctrl.sv =====
// ----------------------------------------------------------------------------
// iec_ctrl
// Controller: sequences digit handling, number conversion, the pending
// multiply or divide and the final sum, as each character requires.
// ----------------------------------------------------------------------------
`default_nettype none

module iec_ctrl
  import iec_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire dp_stat_t stat_i,
  output logic          in_ready_o,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE:    state_d = stat_i.need_finish ? ST_CONV_GO : ST_IDLE;
      ST_CONV_GO:   state_d = ST_CONV_WAIT;
      ST_CONV_WAIT: if (stat_i.unit_done) state_d = ST_OP_GO;
      ST_OP_GO: begin
        if (stat_i.pend == OP_NONE || (stat_i.pend == OP_DIV && stat_i.v_zero))
          state_d = ST_POST;
        else
          state_d = ST_OP_WAIT;
      end
      ST_OP_WAIT:   if (stat_i.unit_done) state_d = ST_POST;
      ST_POST:      if (!(stat_i.last && stat_i.out_busy)) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_DECODE:    cmd_o.digit = 1'b1;
      ST_CONV_GO:   cmd_o.conv_go = 1'b1;
      ST_CONV_WAIT: cmd_o.conv_done = stat_i.unit_done;
      ST_OP_GO: begin
        if (stat_i.pend == OP_DIV && stat_i.v_zero) cmd_o.div0 = 1'b1;
        else if (stat_i.pend != OP_NONE)            cmd_o.op_go = 1'b1;
      end
      ST_OP_WAIT:   cmd_o.op_done = stat_i.unit_done;
      // hold the final result until the output register is free
      ST_POST:      cmd_o.post = !(stat_i.last && stat_i.out_busy);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

// ===== tb/infix_expression_evaluator_core_tb.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core_tb
// Self-checking bench for the character-serial expression evaluator.
// A directed table of expressions (extremes and error statuses) is sent
// first. Random well-formed expressions and noise follow. Each result is
// checked against the value the table gives or else a fixed-point predictor of the evaluator, with random
// idle bursts on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator_core_tb;
  import iec_pkg::*;

  localparam int N_ITEMS = 1350;
  localparam logic [63:0] VMAX_U   = (64'd1 << (VALUE_BITS - 1)) - 64'd1;
  localparam logic [63:0] MANT_TOP = (64'd1 << MANT_BITS) - 64'd1;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    err_e                  status;
  } result_t;

  typedef struct {
    logic [7:0]            ch;
    logic                  last;
    logic                  typed;
    logic [VALUE_BITS-1:0] value;
    err_e                  status;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i = '0;  // [7:0] char_code
  logic                  s_axis_tlast_i = 1'b0;  // last_char
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [VALUE_BITS-1:0] m_axis_tdata_o;  // [47:0] result_value
  logic [1:0]            m_axis_tuser_o;  // [1:0] status

  infix_expression_evaluator_core dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic signed [63:0] sum_acc, term_acc;
  pend_e              op_held;
  logic               neg_next;
  logic [63:0]        mant;
  int unsigned        frac_cnt;
  logic               dot_flag;
  err_e               first_err;

  result_t results_due[$];
  row_t    table_rows[$];
  int      n_errors = 0;
  int      n_sent = 0;
  logic    quiet = 1'b0;

  function automatic void clear_expr();
    sum_acc = 0; term_acc = 0; op_held = OP_NONE; neg_next = 0;
    mant = 0; frac_cnt = 0; dot_flag = 0; first_err = ERR_NONE;
  endfunction

  function automatic void note_err(err_e code);
    if (first_err == ERR_NONE) first_err = code;
  endfunction

  function automatic logic signed [63:0] clamp_mag(logic neg, logic [63:0] mag, logic ovf);
    logic [63:0] lim;
    lim = neg ? VMAX_U + 64'd1 : VMAX_U;
    if (ovf || mag > lim) begin
      mag = lim;
      note_err(ERR_OVF);
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (s > $signed(VMAX_U)) begin
      note_err(ERR_OVF);
      return $signed(VMAX_U);
    end
    if (s < -$signed(VMAX_U) - 1) begin
      note_err(ERR_OVF);
      return -$signed(VMAX_U) - 1;
    end
    return s;
  endfunction

  function automatic logic [63:0] mag_of(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] mul_fx(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    return clamp_mag((a < 0) != (b < 0), prod[FRAC_BITS +: 64], prod[127:64+FRAC_BITS] != 0);
  endfunction

  function automatic logic signed [63:0] div_fx(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] quo;
    if (mag_of(b) == 0) begin
      note_err(ERR_DIV0);
      return 0;
    end
    quo = ({64'd0, mag_of(a)} << FRAC_BITS) / {64'd0, mag_of(b)};
    return clamp_mag((a < 0) != (b < 0), quo[63:0], quo[127:64] != 0);
  endfunction

  // Convert the gathered decimal digits, rounding half up.
  function automatic logic signed [63:0] number_fx();
    logic [63:0] p, q, r, v;
    p = POW10[frac_cnt & 7];
    q = mant / p;
    r = mant % p;
    if (q > (VMAX_U >> FRAC_BITS)) begin
      note_err(ERR_OVF);
      return $signed(VMAX_U);
    end
    v = (q << FRAC_BITS) + (((r << FRAC_BITS) + (p >> 1)) / p);
    return clamp_mag(1'b0, v, 1'b0);
  endfunction

  function automatic void close_number();
    logic signed [63:0] v;
    v = number_fx();
    case (op_held)
      OP_MUL:  term_acc = mul_fx(term_acc, v);
      OP_DIV:  term_acc = div_fx(term_acc, v);
      default: term_acc = neg_next ? -v : v;
    endcase
    mant = 0; frac_cnt = 0; dot_flag = 0;
  endfunction

  function automatic void push_digit(logic [63:0] d);
    if (mant > (MANT_TOP - d) / 10) begin
      mant = MANT_TOP;
      note_err(ERR_OVF);
    end else begin
      mant = mant * 10 + d;
    end
  endfunction

  function automatic logic eval_char(logic [7:0] c, logic last, output result_t r);
    logic is_op;
    is_op = c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!dot_flag) begin
        push_digit(64'(c - CH_ZERO));
      end else if (frac_cnt < MAX_FRAC_DIGITS) begin
        push_digit(64'(c - CH_ZERO));
        frac_cnt++;
      end
    end else if (c == CH_DOT) begin
      dot_flag = 1;
    end else if (is_op) begin
      close_number();
      if (c == CH_PLUS || c == CH_MINUS) begin
        sum_acc  = add_sat(sum_acc, term_acc);
        term_acc = 0;
        neg_next = (c == CH_MINUS);
        op_held  = OP_NONE;
      end else begin
        op_held = (c == CH_STAR) ? OP_MUL : OP_DIV;
      end
    end
    if (!last) return 0;
    if (!is_op) begin
      close_number();
      sum_acc = add_sat(sum_acc, term_acc);
    end
    r.status = (first_err != ERR_NONE) ? first_err : (is_op ? ERR_TRAIL : ERR_NONE);
    r.value  = (r.status == ERR_TRAIL || r.status == ERR_DIV0) ? '0 : sum_acc[VALUE_BITS-1:0];
    clear_expr();
    return 1;
  endfunction

  // Send one character; the transaction completes at the edge where tready is seen.
  task automatic send_char(logic [7:0] c, logic last, logic typed = 0,
                           logic [VALUE_BITS-1:0] tv = '0, err_e ts = ERR_NONE);
    result_t r;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
    if (eval_char(c, last, r)) begin
      if (typed) begin
        r.value  = tv;
        r.status = ts;
      end
      results_due.push_back(r);
    end
  endtask

  function automatic void add_row(logic [7:0] c, logic last, logic typed = 0,
                                  logic [VALUE_BITS-1:0] v = '0, err_e st = ERR_NONE);
    row_t t;
    t.ch = c; t.last = last; t.typed = typed; t.value = v; t.status = st;
    table_rows.push_back(t);
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Build one random expression, mostly well formed.
  function automatic void build_expr(ref logic [7:0] chars[$]);
    int n_terms, nd;
    logic [7:0] ops[4];
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    chars.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    n_terms = $urandom_range(1, 5);
    for (int t = 0; t < n_terms; t++) begin
      nd = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 3);
      repeat (nd) chars.push_back(rand_digit());
      if ($urandom_range(0, 2) == 0) begin
        chars.push_back(CH_DOT);
        repeat ($urandom_range(0, 7)) chars.push_back(rand_digit());
        if ($urandom_range(0, 9) == 0) chars.push_back(CH_DOT);
        if ($urandom_range(0, 9) == 0) chars.push_back(rand_digit());
      end
      if ($urandom_range(0, 12) == 0) chars.push_back(8'($urandom_range(0, 255)));
      if (t < n_terms - 1 || $urandom_range(0, 7) == 0)
        chars.push_back(ops[$urandom_range(0, 3)]);
      if ($urandom_range(0, 15) == 0) chars.push_back(ops[$urandom_range(0, 3)]);
    end
    if (chars.size() == 0) chars.push_back(rand_digit());
  endfunction

  // result side: random stalls
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: result_value %h status %0d",
               m_axis_tdata_o, m_axis_tuser_o);
        n_errors++;
      end else begin
        e = results_due.pop_front();
        if (m_axis_tdata_o !== e.value) begin
          $error("result_value: expected %h, actual %h", e.value, m_axis_tdata_o);
          n_errors++;
        end
        if (m_axis_tuser_o !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, m_axis_tuser_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [7:0] chars[$];
    logic       paused;
    paused = 0;
    clear_expr();
    add_row("5", 1, 1, 48'h50000, ERR_NONE);
    add_row(CH_PLUS, 1, 1, '0, ERR_TRAIL);
    add_row("1", 0);
    add_row(CH_SLASH, 0);
    add_row("0", 1, 1, '0, ERR_DIV0);
    for (int i = 0; i < 10; i++) add_row("9", i == 9, 1, VMAX, ERR_OVF);
    add_row(CH_MINUS, 0);
    add_row(CH_DOT, 0);
    add_row("5", 0);
    add_row(CH_STAR, 0);
    add_row("2", 0);
    add_row(CH_DOT, 0);
    add_row("5", 0);
    add_row("x", 1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_char(table_rows[i].ch, table_rows[i].last, table_rows[i].typed,
                table_rows[i].value, table_rows[i].status);

    while (n_sent < N_ITEMS) begin
      build_expr(chars);
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
      if (!paused && n_sent > N_ITEMS / 2) begin
        // hold off until the evaluator has drained
        paused = 1;
        s_axis_tvalid_i <= 1'b0;
        while (results_due.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (n_sent > N_ITEMS - 150) quiet = 1'b1;
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;

    while (results_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
